/* rtl/flal_pkg.sv */
// shared constants, types and state codes of the free-list allocator
package flal_pkg;

  localparam int unsigned ArenaUnits = 4096;
  localparam int unsigned UnitBytes  = 16;
  localparam int unsigned MinGrow    = 1024;
  localparam int unsigned MinNeed    = 2;

  localparam int unsigned AddrW     = $clog2(ArenaUnits);
  localparam int unsigned SizeW     = AddrW + 1;
  localparam int unsigned BytesW    = 16;
  localparam int unsigned NeedW     = BytesW + 1;
  localparam int unsigned UnitShift = $clog2(UnitBytes);
  localparam int unsigned WalkLimit = 2 * ArenaUnits + 4;
  localparam int unsigned StepW     = $clog2(WalkLimit + 1);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [SizeW-1:0] size_t;
  typedef logic [NeedW-1:0] need_t;
  typedef logic [StepW-1:0] step_t;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic {
    STAT_OK  = 1'b0,
    STAT_OOM = 1'b1
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_FIRST,
    ST_A_EXAM,
    ST_A_SPLIT,
    ST_A_RESUME,
    ST_G_CHK,
    ST_R_CHK,
    ST_PB_START,
    ST_PB_EXAM,
    ST_PB_NX,
    ST_PB_WR,
    ST_DONE
  } state_e;

  // one read address shared by both arrays, one write port per array
  typedef struct packed {
    addr_t rd_addr;
    logic  lk_we;
    addr_t lk_waddr;
    addr_t lk_wdata;
    logic  sz_we;
    addr_t sz_waddr;
    size_t sz_wdata;
  } heap_req_t;

  typedef struct packed {
    addr_t link;
    size_t size;
  } heap_rsp_t;

endpackage

/* rtl/flal_req_if.sv */
// request channel: command, byte count and block address
interface flal_req_if import flal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BytesW-1:0] request_bytes;
  logic [AddrW-1:0]  block_addr;

  modport source (output valid, output cmd, output request_bytes, output block_addr,
                  input ready);
  modport sink (input valid, input cmd, input request_bytes, input block_addr,
                output ready);
endinterface

/* rtl/flal_rsp_if.sv */
// result channel: status and granted payload address
interface flal_rsp_if import flal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [AddrW-1:0] payload_addr;

  modport source (output valid, output status, output payload_addr, input ready);
  modport sink (input valid, input status, input payload_addr, output ready);
endinterface

/* rtl/flal_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
module flal_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/flal_heap.sv */
// unit store: link and size arrays, anchor unit reads self-linked size zero until written
module flal_heap import flal_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  heap_req_t heap_req_i,
  output heap_rsp_t heap_rsp_o
);

  addr_t lk_rdata;
  size_t sz_rdata;
  logic  lk0_vld_q, lk0_vld_d;
  logic  sz0_vld_q, sz0_vld_d;
  logic  dflt_lk_q, dflt_lk_d;
  logic  dflt_sz_q, dflt_sz_d;
  logic  rd_zero;

  flal_ram #(.Width(AddrW), .Depth(ArenaUnits)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (heap_req_i.lk_we),
    .waddr_i(heap_req_i.lk_waddr),
    .wdata_i(heap_req_i.lk_wdata),
    .raddr_i(heap_req_i.rd_addr),
    .rdata_o(lk_rdata)
  );

  flal_ram #(.Width(SizeW), .Depth(ArenaUnits)) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (heap_req_i.sz_we),
    .waddr_i(heap_req_i.sz_waddr),
    .wdata_i(heap_req_i.sz_wdata),
    .raddr_i(heap_req_i.rd_addr),
    .rdata_o(sz_rdata)
  );

  assign rd_zero = (heap_req_i.rd_addr == '0);

  // default is sampled with the read so a same-cycle write still reads old data
  always_comb begin
    lk0_vld_d = lk0_vld_q | (heap_req_i.lk_we && heap_req_i.lk_waddr == '0);
    sz0_vld_d = sz0_vld_q | (heap_req_i.sz_we && heap_req_i.sz_waddr == '0);
    dflt_lk_d = rd_zero && !lk0_vld_q;
    dflt_sz_d = rd_zero && !sz0_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk0_vld_q <= 1'b0;
      sz0_vld_q <= 1'b0;
      dflt_lk_q <= 1'b0;
      dflt_sz_q <= 1'b0;
    end else begin
      lk0_vld_q <= lk0_vld_d;
      sz0_vld_q <= sz0_vld_d;
      dflt_lk_q <= dflt_lk_d;
      dflt_sz_q <= dflt_sz_d;
    end
  end

  assign heap_rsp_o.link = dflt_lk_q ? '0 : lk_rdata;
  assign heap_rsp_o.size = dflt_sz_q ? '0 : sz_rdata;

endmodule

/* rtl/flal_ctrl.sv */
// allocator sequencer: next-fit search, split, growth, ordered insert with coalescing
module flal_ctrl import flal_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  flal_req_if.sink   req_i,
  flal_rsp_if.source rsp_o,
  output heap_req_t  heap_req_o,
  input  heap_rsp_t  heap_rsp_i
);

  state_e state_q, state_d;

  need_t need_q, need_d;
  addr_t h_q, h_d;
  addr_t p_q, p_d;
  addr_t prev_q, prev_d;
  addr_t nx_q, nx_d;
  size_t size_p_q, size_p_d;
  size_t size_h_q, size_h_d;
  addr_t link_h_q, link_h_d;
  step_t a_steps_q, a_steps_d;
  step_t pb_steps_q, pb_steps_d;
  logic  pb_grow_q, pb_grow_d;
  addr_t free_start_q, free_start_d;
  size_t heap_break_q, heap_break_d;
  logic  res_status_q, res_status_d;
  addr_t res_payload_q, res_payload_d;
  logic  out_valid_q, out_valid_d;
  logic  out_status_q, out_status_d;
  addr_t out_payload_q, out_payload_d;

  logic                in_acc;
  logic                is_rel;
  need_t               need_units, need_raw, need_calc;
  addr_t               rel_h;
  logic                rel_bad;
  logic                rchk_bad;
  logic                size_ge, size_eq;
  logic                at_start;
  logic                a_steps_out, pb_steps_out;
  size_t               rem;
  addr_t               q_addr;
  need_t               grow_n;
  logic [NeedW:0]      grow_end;
  logic                grow_fail;
  addr_t               pb_nx;
  logic                pb_brk;
  logic [SizeW:0]      h_end, p_end;
  logic                merge_nx, merge_p;
  size_t               size_h_m;
  addr_t               link_h_m;
  logic                out_load;

  assign in_acc = req_i.valid && req_i.ready;
  assign is_rel = (req_i.cmd == CMD_RELEASE);

  // units needed, header included, at least one payload unit
  assign need_units = (NeedW'(req_i.request_bytes) + NeedW'(UnitBytes - 1)) >> UnitShift;
  assign need_raw   = need_units + NeedW'(1);
  assign need_calc  = (need_raw < NeedW'(MinNeed)) ? NeedW'(MinNeed) : need_raw;

  assign rel_h    = req_i.block_addr - AddrW'(1);
  assign rel_bad  = (req_i.block_addr < AddrW'(MinNeed)) || (SizeW'(rel_h) >= heap_break_q);
  assign rchk_bad = (heap_rsp_i.size == '0) ||
                    ((SizeW+1)'(h_q) + (SizeW+1)'(heap_rsp_i.size) >
                     (SizeW+1)'(heap_break_q));

  assign size_ge     = NeedW'(heap_rsp_i.size) >= need_q;
  assign size_eq     = NeedW'(heap_rsp_i.size) == need_q;
  assign at_start    = (p_q == free_start_q);
  assign a_steps_out = (a_steps_q >= StepW'(WalkLimit));
  assign pb_steps_out = (pb_steps_q >= StepW'(WalkLimit));

  // split gives away the tail of the block
  assign rem    = heap_rsp_i.size - need_q[SizeW-1:0];
  assign q_addr = p_q + rem[AddrW-1:0];

  assign grow_n    = (need_q < NeedW'(MinGrow)) ? NeedW'(MinGrow) : need_q;
  assign grow_end  = (NeedW+1)'(heap_break_q) + (NeedW+1)'(grow_n);
  assign grow_fail = (grow_end > (NeedW+1)'(ArenaUnits)) ||
                     (heap_break_q >= SizeW'(ArenaUnits));

  // insertion point: between p and its successor, or at the wrap of the ring
  assign pb_nx  = heap_rsp_i.link;
  assign pb_brk = (h_q > p_q && h_q < pb_nx) ||
                  (p_q >= pb_nx && (h_q > p_q || h_q < pb_nx));

  assign h_end    = (SizeW+1)'(h_q) + (SizeW+1)'(size_h_q);
  assign merge_nx = (h_end == (SizeW+1)'(nx_q));
  assign size_h_m = merge_nx ? size_h_q + heap_rsp_i.size : size_h_q;
  assign link_h_m = merge_nx ? heap_rsp_i.link : nx_q;
  assign p_end    = (SizeW+1)'(p_q) + (SizeW+1)'(size_p_q);
  assign merge_p  = (p_end == (SizeW+1)'(h_q));

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin : p_next_state
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (!is_rel) begin
            state_d = ST_A_FIRST;
          end else if (rel_bad) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_R_CHK;
          end
        end
      end
      ST_A_FIRST: state_d = ST_A_EXAM;
      ST_A_EXAM: begin
        if (size_ge) begin
          state_d = size_eq ? ST_DONE : ST_A_SPLIT;
        end else if (at_start) begin
          state_d = ST_G_CHK;
        end else if (a_steps_out) begin
          state_d = ST_DONE;
        end
      end
      ST_A_SPLIT:  state_d = ST_DONE;
      ST_G_CHK:    state_d = grow_fail ? ST_DONE : ST_PB_START;
      ST_R_CHK:    state_d = rchk_bad ? ST_DONE : ST_PB_START;
      ST_PB_START: state_d = ST_PB_EXAM;
      ST_PB_EXAM: begin
        if (pb_brk) begin
          state_d = ST_PB_NX;
        end else if (pb_steps_out) begin
          state_d = ST_DONE;
        end
      end
      ST_PB_NX:    state_d = ST_PB_WR;
      ST_PB_WR:    state_d = pb_grow_q ? ST_A_RESUME : ST_DONE;
      ST_A_RESUME: state_d = a_steps_out ? ST_DONE : ST_A_FIRST;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin : p_datapath
    need_d        = need_q;
    h_d           = h_q;
    p_d           = p_q;
    prev_d        = prev_q;
    nx_d          = nx_q;
    size_p_d      = size_p_q;
    size_h_d      = size_h_q;
    link_h_d      = link_h_q;
    a_steps_d     = a_steps_q;
    pb_steps_d    = pb_steps_q;
    pb_grow_d     = pb_grow_q;
    free_start_d  = free_start_q;
    heap_break_d  = heap_break_q;
    res_status_d  = res_status_q;
    res_payload_d = res_payload_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          need_d        = need_calc;
          h_d           = rel_h;
          prev_d        = free_start_q;
          a_steps_d     = '0;
          res_status_d  = STAT_OK;
          res_payload_d = '0;
        end
      end
      ST_A_FIRST: p_d = heap_rsp_i.link;
      ST_A_EXAM: begin
        if (size_ge) begin
          free_start_d = prev_q;
          if (size_eq) begin
            res_payload_d = p_q + AddrW'(1);
          end else begin
            p_d           = q_addr;
            res_payload_d = q_addr + AddrW'(1);
          end
        end else if (!at_start) begin
          if (a_steps_out) begin
            res_status_d = STAT_OOM;
          end else begin
            a_steps_d = a_steps_q + StepW'(1);
            prev_d    = p_q;
            p_d       = heap_rsp_i.link;
          end
        end
      end
      ST_G_CHK: begin
        if (grow_fail) begin
          res_status_d = STAT_OOM;
        end else begin
          h_d          = heap_break_q[AddrW-1:0];
          size_h_d     = grow_n[SizeW-1:0];
          heap_break_d = grow_end[SizeW-1:0];
          pb_grow_d    = 1'b1;
        end
      end
      ST_R_CHK: begin
        size_h_d  = heap_rsp_i.size;
        pb_grow_d = 1'b0;
      end
      ST_PB_START: begin
        p_d        = free_start_q;
        pb_steps_d = '0;
      end
      ST_PB_EXAM: begin
        if (pb_brk) begin
          nx_d     = pb_nx;
          size_p_d = heap_rsp_i.size;
        end else if (pb_steps_out) begin
          if (pb_grow_q) begin
            res_status_d = STAT_OOM;
          end
        end else begin
          pb_steps_d = pb_steps_q + StepW'(1);
          p_d        = pb_nx;
        end
      end
      ST_PB_NX: begin
        size_h_d = size_h_m;
        link_h_d = link_h_m;
      end
      ST_PB_WR: free_start_d = p_q;
      ST_A_RESUME: begin
        if (a_steps_out) begin
          res_status_d = STAT_OOM;
        end else begin
          a_steps_d = a_steps_q + StepW'(1);
          prev_d    = free_start_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin : p_outputs
    heap_req_o = '0;
    case (state_q)
      ST_IDLE: heap_req_o.rd_addr = is_rel ? rel_h : free_start_q;
      ST_A_FIRST: heap_req_o.rd_addr = heap_rsp_i.link;
      ST_A_EXAM: begin
        if (size_ge) begin
          if (size_eq) begin
            heap_req_o.lk_we    = 1'b1;
            heap_req_o.lk_waddr = prev_q;
            heap_req_o.lk_wdata = heap_rsp_i.link;
          end else begin
            heap_req_o.sz_we    = 1'b1;
            heap_req_o.sz_waddr = p_q;
            heap_req_o.sz_wdata = rem;
          end
        end else begin
          heap_req_o.rd_addr = heap_rsp_i.link;
        end
      end
      ST_A_SPLIT: begin
        heap_req_o.sz_we    = 1'b1;
        heap_req_o.sz_waddr = p_q;
        heap_req_o.sz_wdata = need_q[SizeW-1:0];
      end
      ST_G_CHK: begin
        if (!grow_fail) begin
          heap_req_o.sz_we    = 1'b1;
          heap_req_o.sz_waddr = heap_break_q[AddrW-1:0];
          heap_req_o.sz_wdata = grow_n[SizeW-1:0];
          heap_req_o.lk_we    = 1'b1;
          heap_req_o.lk_waddr = heap_break_q[AddrW-1:0];
          heap_req_o.lk_wdata = '0;
        end
      end
      ST_PB_START: heap_req_o.rd_addr = free_start_q;
      ST_PB_EXAM:  heap_req_o.rd_addr = pb_nx;
      ST_PB_NX: begin
        heap_req_o.lk_we    = 1'b1;
        heap_req_o.lk_waddr = h_q;
        heap_req_o.lk_wdata = link_h_m;
        heap_req_o.sz_we    = 1'b1;
        heap_req_o.sz_waddr = h_q;
        heap_req_o.sz_wdata = size_h_m;
      end
      ST_PB_WR: begin
        heap_req_o.lk_we    = 1'b1;
        heap_req_o.lk_waddr = p_q;
        if (merge_p) begin
          heap_req_o.lk_wdata = link_h_q;
          heap_req_o.sz_we    = 1'b1;
          heap_req_o.sz_waddr = p_q;
          heap_req_o.sz_wdata = size_p_q + size_h_q;
        end else begin
          heap_req_o.lk_wdata = h_q;
        end
      end
      ST_A_RESUME: heap_req_o.rd_addr = free_start_q;
      default: ;
    endcase
  end

  // output register lets the next item in while a result waits
  always_comb begin : p_out_reg
    out_status_d  = out_status_q;
    out_payload_d = out_payload_q;
    if (out_load) begin
      out_valid_d   = 1'b1;
      out_status_d  = res_status_q;
      out_payload_d = (res_status_q == STAT_OOM) ? '0 : res_payload_q;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.payload_addr = out_payload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      free_start_q <= '0;
      heap_break_q <= SizeW'(1);
      pb_grow_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_start_q <= free_start_d;
      heap_break_q <= heap_break_d;
      pb_grow_q    <= pb_grow_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q        <= need_d;
    h_q           <= h_d;
    p_q           <= p_d;
    prev_q        <= prev_d;
    nx_q          <= nx_d;
    size_p_q      <= size_p_d;
    size_h_q      <= size_h_d;
    link_h_q      <= link_h_d;
    a_steps_q     <= a_steps_d;
    pb_steps_q    <= pb_steps_d;
    res_status_q  <= res_status_d;
    res_payload_q <= res_payload_d;
    out_status_q  <= out_status_d;
    out_payload_q <= out_payload_d;
  end

endmodule

/* rtl/free_list_allocator_unit.sv */
// allocate: next-fit walk of the free list; when no block fits, the heap grows, the new
//   block is inserted into the free list and the walk resumes
// release: an out-of-range address or a bad stored size ends the item with no walk,
//   else the free list is walked to insert the block
// one item at a time, paced by the single read port of the unit store
// reset: anchor unit self-linked with size zero, break at unit 1, no clearing pass
module free_list_allocator_unit import flal_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  flal_req_if.sink   req_i,
  flal_rsp_if.source rsp_o
);

  heap_req_t heap_req;
  heap_rsp_t heap_rsp;

  flal_ctrl u_flal_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .heap_req_o(heap_req),
    .heap_rsp_i(heap_rsp)
  );

  flal_heap u_flal_heap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .heap_req_i(heap_req),
    .heap_rsp_o(heap_rsp)
  );

endmodule

/* rtl/flal_checker.sv */
// port-level checks for the allocator, bound to the top level
module flal_port_checker import flal_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             out_status_i,
  input logic [AddrW-1:0] out_payload_addr_i
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items taken in but whose result has not left yet
  always_comb begin
    pend_d = pend_q + 2'(in_acc) - 2'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  a_oom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == STAT_OOM |-> out_payload_addr_i == '0)
    else $error("failed allocate shows a nonzero address");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("new item taken while the previous one is still in work");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result shown with no item outstanding");

  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q <= 2'd1)
    else $error("more than two items outstanding");

endmodule

bind free_list_allocator_unit flal_port_checker u_flal_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (req_i.valid),
  .in_ready_i        (req_i.ready),
  .out_valid_i       (rsp_o.valid),
  .out_ready_i       (rsp_o.ready),
  .out_status_i      (rsp_o.status),
  .out_payload_addr_i(rsp_o.payload_addr)
);
